@@ hdl/padu_pkg.sv @@
// Shared types and constants for the plateau-aware peak detector.
`timescale 1ns / 1ps
package padu_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned IndexWidth  = 16;
  localparam logic [CountWidth-1:0] MaxPeaksReset = 16'hFFFF;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [IndexWidth-1:0] index_t;

  typedef struct packed {
    logic advance;
    logic hit;
  } core_ctl_t;

endpackage

@@ hdl/plateau_aware_peak_detector_unit.sv @@
// Top level of the plateau-aware peak detector.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid / in_stall carry one signed sample per transfer with
//   in_sequence_end marking the last sample of a sequence. Runs of equal samples
//   form a plateau; a plateau entered by a rise and left by a fall is a peak.
//   Result channel: out_valid / out_stall carry one peak per transfer with its
//   value and the index of the plateau's first sample, sent when the falling
//   sample is processed. Runs touching either end of a sequence are never peaks.
//   Configuration: cfg_wr_en writes cfg_wr_data to max_peaks, the most peaks
//   reported per sequence; write it only while the block is idle.
//   Result path: the falling sample is held in the input register, and the peak it
//   ends is then loaded into the result register and presented from there.
//   Throughput: one sample per cycle while no peak waits on a stalled result, set
//   by the single compare-and-update path between the input and result registers.
//   Reset (rst_n low, synchronous): both registers empty, sequence state cleared,
//   max_peaks set to 65535.
//   Stall: a stalled result holds; samples that make no peak keep flowing, and a
//   sample that makes one waits in the input register, which then stalls input.
module plateau_aware_peak_detector_unit #(
  parameter int unsigned SAMPLE_WIDTH        = 16,
  parameter int unsigned MAX_SEQUENCE_LENGTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  padu_pkg::count_t               cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_sequence_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_peak_value,
  output padu_pkg::index_t               out_peak_index
);
  import padu_pkg::*;

  core_ctl_t                      ctl;
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                           s1_last;
  logic                           slot_free;
  logic signed [SAMPLE_WIDTH-1:0] peak_value;
  index_t                         peak_index;

  padu_in_stage #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_sequence_end(in_sequence_end),
    .ctl            (ctl),
    .s1_valid       (s1_valid),
    .s1_sample      (s1_sample),
    .s1_last        (s1_last)
  );

  padu_core #(
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .MAX_SEQUENCE_LENGTH(MAX_SEQUENCE_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s1_valid   (s1_valid),
    .s1_sample  (s1_sample),
    .s1_last    (s1_last),
    .slot_free  (slot_free),
    .ctl        (ctl),
    .peak_value (peak_value),
    .peak_index (peak_index)
  );

  padu_out_stage #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .peak_value    (peak_value),
    .peak_index    (peak_index),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_peak_value(out_peak_value),
    .out_peak_index(out_peak_index)
  );

  a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_held_sample_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && !slot_free)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

@@ hdl/padu_in_stage.sv @@
// Input register stage of the peak detector.
`timescale 1ns / 1ps
module padu_in_stage #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_sequence_end,
  input  padu_pkg::core_ctl_t            ctl,
  output logic                           s1_valid,
  output logic signed [SAMPLE_WIDTH-1:0] s1_sample,
  output logic                           s1_last
);
  import padu_pkg::*;

  logic                           valid_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           last_r;

  assign in_stall  = valid_r && !ctl.advance;
  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;
  assign s1_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample_r <= in_sample;
      last_r   <= in_sequence_end;
    end
  end

endmodule

@@ hdl/padu_core.sv @@
// Plateau tracking, peak decision and per-sequence state.
`timescale 1ns / 1ps
module padu_core #(
  parameter int unsigned SAMPLE_WIDTH        = 16,
  parameter int unsigned MAX_SEQUENCE_LENGTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  padu_pkg::count_t               cfg_wr_data,
  input  logic                           s1_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] s1_sample,
  input  logic                           s1_last,
  input  logic                           slot_free,
  output padu_pkg::core_ctl_t            ctl,
  output logic signed [SAMPLE_WIDTH-1:0] peak_value,
  output padu_pkg::index_t               peak_index
);
  import padu_pkg::*;

  localparam int unsigned PosWidth = $clog2(MAX_SEQUENCE_LENGTH);
  localparam logic [PosWidth-1:0] PosLimit = PosWidth'(MAX_SEQUENCE_LENGTH - 1);

  count_t                         max_peaks_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_r;
  logic [PosWidth-1:0]            pos_r;
  logic [PosWidth-1:0]            run_r;
  logic                           rose_r;
  count_t                         cnt_r;

  logic first;
  logic fall;
  logic rise;
  logic report;

  assign first  = (pos_r == '0);
  assign fall   = s1_sample < prev_r;
  assign rise   = s1_sample > prev_r;
  assign report = !first && fall && rose_r && (cnt_r < max_peaks_r);

  assign ctl.advance = s1_valid && (!report || slot_free);
  assign ctl.hit     = s1_valid && report && slot_free;
  assign peak_value  = prev_r;
  assign peak_index  = IndexWidth'(run_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_peaks_r <= MaxPeaksReset;
    end else if (cfg_wr_en) begin
      max_peaks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pos_r  <= '0;
      run_r  <= '0;
      rose_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.advance) begin
      if (s1_last) begin
        prev_r <= '0;
        pos_r  <= '0;
        run_r  <= '0;
        rose_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        prev_r <= s1_sample;
        if (pos_r != PosLimit) begin
          pos_r <= pos_r + 1'b1;
        end
        if (ctl.hit) begin
          cnt_r <= cnt_r + 1'b1;
        end
        priority if (first) begin
          run_r  <= '0;
          rose_r <= 1'b0;
        end else if (fall) begin
          run_r  <= pos_r;
          rose_r <= 1'b0;
        end else if (rise) begin
          run_r  <= pos_r;
          rose_r <= 1'b1;
        end else begin
          run_r  <= run_r;
          rose_r <= rose_r;
        end
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance && s1_last |=> pos_r == '0 && cnt_r == '0 && !rose_r)
    else $error("sequence state not cleared after last sample");

  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance && !s1_last && pos_r != PosLimit |=>
      pos_r == PosWidth'($past(pos_r) + 1'b1))
    else $error("sample position did not advance");

  a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hit && !s1_last |=> cnt_r == CountWidth'($past(cnt_r) + 1'b1))
    else $error("peak count did not advance on a reported peak");

  a_hit_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hit |-> rose_r && !first)
    else $error("peak reported without a rising edge into the run");

endmodule

@@ hdl/padu_out_stage.sv @@
// Result register of the peak detector.
`timescale 1ns / 1ps
module padu_out_stage #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  padu_pkg::core_ctl_t            ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] peak_value,
  input  padu_pkg::index_t               peak_index,
  output logic                           slot_free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_peak_value,
  output padu_pkg::index_t               out_peak_index
);
  import padu_pkg::*;

  logic                           valid_r;
  logic signed [SAMPLE_WIDTH-1:0] value_r;
  index_t                         index_r;

  assign slot_free      = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_peak_value = value_r;
  assign out_peak_index = index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.hit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit) begin
      value_r <= peak_value;
      index_r <= peak_index;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(value_r) && $stable(index_r))
    else $error("stalled result overwritten");

  a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hit |=> valid_r)
    else $error("reported peak not presented");

  a_hit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hit && valid_r |-> !out_stall)
    else $error("peak loaded while result register is held");

endmodule

@@ tb/peak_monitor.sv @@
// Checker that predicts detected peaks from sample transfers and compares result transfers.
`timescale 1ns / 1ps
module peak_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  padu_pkg::count_t   cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_sequence_end,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_peak_value,
  input  padu_pkg::index_t   out_peak_index,
  output int unsigned        mismatches,
  output int unsigned        peaks_due
);
  import padu_pkg::*;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t value;
    index_t  index;
  } peak_t;

  localparam index_t LastPosition = '1;

  peak_t       expected_peaks[$];
  sample_t     prev_sample;
  index_t      position;
  index_t      run_start;
  logic        rose;
  count_t      reported;
  count_t      peak_limit = MaxPeaksReset;
  int unsigned fails = 0;

  function automatic void clear_sequence();
    prev_sample = '0;
    position    = '0;
    run_start   = '0;
    rose        = 1'b0;
    reported    = '0;
  endfunction

  task automatic track_sample(input sample_t s, input logic last);
    peak_t found;
    if (position == '0) begin
      run_start = '0;
      rose      = 1'b0;
    end else if (s < prev_sample) begin
      if (rose && reported < peak_limit) begin
        found.value = prev_sample;
        found.index = run_start;
        expected_peaks.push_back(found);
        reported++;
      end
      run_start = position;
      rose      = 1'b0;
    end else if (s > prev_sample) begin
      run_start = position;
      rose      = 1'b1;
    end
    prev_sample = s;
    if (position != LastPosition) position++;
    if (last) clear_sequence();
  endtask

  always @(posedge clk) begin : watch
    peak_t due;
    if (!rst_n) begin
      clear_sequence();
      peak_limit = MaxPeaksReset;
      expected_peaks.delete();
    end else begin
      if (cfg_wr_en) peak_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_peaks.size() == 0) begin
          $error("unexpected peak: peak_value %0d, peak_index %0d",
                 out_peak_value, out_peak_index);
          fails++;
        end else begin
          due = expected_peaks.pop_front();
          if (out_peak_value !== due.value) begin
            $error("peak_value: expected %0d, actual %0d", due.value, out_peak_value);
            fails++;
          end
          if (out_peak_index !== due.index) begin
            $error("peak_index: expected %0d, actual %0d", due.index, out_peak_index);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) track_sample(in_sample, in_sequence_end);
    end
    peaks_due  <= expected_peaks.size();
    mismatches <= fails;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives samples and peak limits into the detector and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import padu_pkg::*;

  typedef logic signed [15:0] sample_t;

  localparam int MaxGap     = 17;
  localparam int PhaseItems = 150;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_wr_en       = 1'b0;
  count_t      cfg_wr_data     = '0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  sample_t     in_sample       = '0;
  logic        in_sequence_end = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  sample_t     out_peak_value;
  index_t      out_peak_index;
  int unsigned mismatches;
  int unsigned peaks_due;
  bit          calm            = 1'b0;

  plateau_aware_peak_detector_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_sequence_end (in_sequence_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_value  (out_peak_value),
    .out_peak_index  (out_peak_index)
  );

  peak_monitor peak_watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_sequence_end (in_sequence_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_value  (out_peak_value),
    .out_peak_index  (out_peak_index),
    .mismatches      (mismatches),
    .peaks_due       (peaks_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("plateau_aware_peak_detector_unit verification failed");
    $finish;
  end

  initial begin : drain
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, MaxGap);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic push_sample(input sample_t s, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_sequence_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (peaks_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_peak_limit(input count_t limit);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_walk(input int len);
    int      level;
    int      span;
    int      pick;
    sample_t raw;
    raw   = $urandom;
    level = $urandom_range(0, 1) ? int'(raw) : int'($urandom_range(0, 40)) - 20;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 3);
      span = (pick == 3) ? 65535 : (pick == 2) ? 2000 : 15;
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3, 4, 5: level = level + 1 + int'($urandom_range(0, span));
        6, 7, 8: level = level - 1 - int'($urandom_range(0, span));
        default: begin
          raw   = $urandom;
          level = raw;
        end
      endcase
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      push_sample(sample_t'(level), i == len - 1);
    end
  endtask

  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) push_sample(sample_t'($urandom), i == len - 1);
  endtask

  task automatic run_phase(input count_t limit);
    int sent;
    int len;
    int kind;
    sent = 0;
    set_peak_limit(limit);
    while (sent < PhaseItems) begin
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, 2);
        send_walk(len);
      end else if (kind == 1) begin
        len = $urandom_range(1, 30);
        send_noise(len);
      end else begin
        len = $urandom_range(3, 40);
        send_walk(len);
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_peak_limit(MaxPeaksReset);
    // short sequences
    push_sample(16'sd5, 1'b1);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd7, 1'b1);
    // leading plateau, then a peak left by the final sample
    push_sample(16'sd9, 1'b0);
    push_sample(16'sd9, 1'b0);
    push_sample(16'sd2, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd1, 1'b1);
    // full-scale swing, rising run left open
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd4, 1'b1);
    // trailing plateau
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(16'sd3, 1'b1);

    run_phase(16'd0);
    run_phase(16'd1);
    run_phase(16'd2);
    run_phase(16'd3);
    run_phase(MaxPeaksReset);
    run_phase(count_t'($urandom_range(4, 20)));
    run_phase(16'd1);
    run_phase(count_t'($urandom_range(1, 65535)));

    settle();
    repeat (2) @(posedge clk);
    if (mismatches == 0 && peaks_due == 0) begin
      $display("plateau_aware_peak_detector_unit verification clean");
    end else begin
      $display("plateau_aware_peak_detector_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/padu_pkg.sv
hdl/padu_in_stage.sv
hdl/padu_core.sv
hdl/padu_out_stage.sv
hdl/plateau_aware_peak_detector_unit.sv
tb/peak_monitor.sv
tb/tb.sv
